/* rtl/core/oaht_pkg.sv */
// Package: constants, codes and types for the open-address hash table
package oaht_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int HANDLE_BITS = 16;
    localparam int HANDLE_W    = HANDLE_BITS;
    localparam int SUM_W       = 12;
    localparam int HOME_BASE   = 7;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_NO_SLOT   = 3'd4;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic [0:0] REG_TABLE_SIZE = 1'd0;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] entry_handle;
    } t_req;

    typedef struct packed {
        logic [2:0]          status;
        logic [7:0]          slot_index;
        logic [HANDLE_W-1:0] found_handle;
        logic [8:0]          occupancy;
    } t_rsp;

    // Cell write command from the sequencer to the cell store
    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     addr;
        logic [1:0]           mark;
        logic                 wr_data;
        logic [KEY_W-1:0]     key;
        logic [HANDLE_W-1:0]  handle;
    } t_cell_wr;

    typedef struct packed {
        logic [1:0]          mark;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_cell_rd;
endpackage

/* rtl/core/oaht_if.sv */
// Interfaces: valid/ready request and response channels
interface oaht_req_if;
    import oaht_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if;
    import oaht_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/oaht_cells.sv */
// Cell store: mark, key and handle memories with registered read
module oaht_cells
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  t_cell_wr         i_wr,
    output t_cell_rd         o_rd
);
    logic [1:0]          r_marks [TABLE_DEPTH];
    logic [KEY_W-1:0]    r_keys  [TABLE_DEPTH];
    logic [HANDLE_W-1:0] r_hdls  [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_marks[i_wr.addr] <= i_wr.mark;
        end
        o_rd.mark <= r_marks[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we && i_wr.wr_data) begin
            r_keys[i_wr.addr] <= i_wr.key;
            r_hdls[i_wr.addr] <= i_wr.handle;
        end
        o_rd.key    <= r_keys[i_rd_addr];
        o_rd.handle <= r_hdls[i_rd_addr];
    end
endmodule

/* rtl/core/oaht_seq.sv */
// Sequencer: hash, quadratic probe walk with two modular adders
module oaht_seq
    import oaht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [8:0]       i_table_size,
    oaht_req_if.sink         req,
    oaht_rsp_if.source       rsp,
    output logic [IDX_W-1:0] o_rd_addr,
    output t_cell_wr         o_wr,
    input  t_cell_rd         i_rd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    // (a + b) mod m, operands already below m
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b,
                                                 input logic [CNT_W-1:0] m);
        logic [CNT_W:0] s;
        s = {2'b0, a} + {2'b0, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[IDX_W-1:0];
    endfunction

    logic [2:0]          r_state, n_state;
    t_req                r_req, n_req;
    logic [CNT_W-1:0]    r_size, n_size;
    logic [SUM_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_t, n_t;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [IDX_W-1:0]    r_step, n_step;
    logic [IDX_W-1:0]    r_two, n_two;
    logic                r_free_ok, n_free_ok;
    logic [IDX_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_used, n_used;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;
    t_cell_wr            r_wr, n_wr;
    logic [IDX_W-1:0]    r_clr, n_clr;

    logic [SUM_W-1:0]    w_bytesum;
    logic [CNT_W-1:0]    w_size;
    logic [SUM_W-1:0]    w_size8;
    logic                w_hit;
    logic                w_free;
    logic [CNT_W-1:0]    w_tn;
    logic [IDX_W-1:0]    w_ins_slot;

    always_comb begin
        w_bytesum = SUM_W'(HOME_BASE);
        for (int b = 0; b < KEY_BYTES; b++)
            w_bytesum = w_bytesum + SUM_W'(req.payload.key[8*b +: 8]);
        if (i_table_size == '0) w_size = CNT_W'(1);
        else if (i_table_size > 9'(TABLE_DEPTH)) w_size = CNT_W'(TABLE_DEPTH);
        else w_size = CNT_W'(i_table_size);
    end

    assign w_size8    = {r_size, 3'b000};
    assign w_hit      = (i_rd.mark == MARK_USED) && (i_rd.key == r_req.key);
    assign w_free     = (i_rd.mark != MARK_USED);
    assign w_tn       = r_t + CNT_W'(1);
    assign w_ins_slot = r_free_ok ? r_free : r_slot;
    assign o_rd_addr  = r_slot;
    assign o_wr       = r_wr;
    assign req.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign rsp.valid  = r_out_valid;
    assign rsp.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_size      = r_size;
        n_acc       = r_acc;
        n_t         = r_t;
        n_slot      = r_slot;
        n_step      = r_step;
        n_two       = r_two;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_clr       = r_clr;
        n_wr        = r_wr;
        n_wr.we     = 1'b0;
        if (rsp.valid && rsp.ready) n_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_wr  = '{we: 1'b1, addr: r_clr, mark: MARK_EMPTY, wr_data: 1'b0,
                          key: '0, handle: '0};
                n_clr = r_clr + IDX_W'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req.valid && req.ready) begin
                    n_req     = req.payload;
                    n_size    = w_size;
                    n_acc     = w_bytesum;
                    n_t       = '0;
                    n_step    = (w_size == CNT_W'(1)) ? '0 : IDX_W'(1);
                    n_two     = (w_size <= CNT_W'(2)) ? '0 : IDX_W'(2);
                    n_free_ok = 1'b0;
                    n_state   = S_HASH;
                end
            end
            S_HASH: begin
                // Reduce by repeated subtraction of eight times the modulus or the modulus
                if (r_acc >= w_size8) begin
                    n_acc = r_acc - w_size8;
                end else if (r_acc >= SUM_W'(r_size)) begin
                    n_acc = r_acc - SUM_W'(r_size);
                end else begin
                    n_slot = IDX_W'(r_acc);
                    if (r_req.kind == KIND_INSERT && r_used >= r_size) begin
                        n_out   = '{status: ST_FULL, slot_index: '0, found_handle: '0,
                                    occupancy: r_used};
                        n_state = S_DONE;
                    end else if (!(r_req.kind inside {KIND_INSERT, KIND_REMOVE,
                                                      KIND_LOOKUP})) begin
                        n_out   = '{status: ST_NOT_FOUND, slot_index: '0,
                                    found_handle: '0, occupancy: r_used};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: n_state = S_WAIT;
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                // Advance to probe t+1: slot += 2t+1, step += 2, both mod size
                n_t     = w_tn;
                n_slot  = mod_add(r_slot, r_step, r_size);
                n_step  = mod_add(r_step, r_two, r_size);
                n_state = S_ADDR;
                if (w_free && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_slot;
                end
                if (w_hit) begin
                    n_state = S_DONE;
                    case (r_req.kind)
                        KIND_INSERT: begin
                            n_out = '{status: ST_DUP, slot_index: '0, found_handle: '0,
                                      occupancy: r_used};
                        end
                        KIND_REMOVE: begin
                            n_wr   = '{we: 1'b1, addr: r_slot, mark: MARK_DELETED,
                                       wr_data: 1'b0, key: r_req.key,
                                       handle: r_req.entry_handle};
                            n_used = r_used - CNT_W'(1);
                            n_out  = '{status: ST_OK, slot_index: r_slot, found_handle: '0,
                                       occupancy: r_used - CNT_W'(1)};
                        end
                        default: begin
                            n_out = '{status: ST_OK, slot_index: r_slot,
                                      found_handle: i_rd.handle, occupancy: r_used};
                        end
                    endcase
                end else if (i_rd.mark == MARK_EMPTY || w_tn == r_size) begin
                    n_state = S_DONE;
                    if (r_req.kind == KIND_INSERT) begin
                        if (r_free_ok || w_free) begin
                            n_wr   = '{we: 1'b1, addr: w_ins_slot, mark: MARK_USED,
                                       wr_data: 1'b1, key: r_req.key,
                                       handle: r_req.entry_handle};
                            n_used = r_used + CNT_W'(1);
                            n_out  = '{status: ST_OK, slot_index: w_ins_slot,
                                       found_handle: '0, occupancy: r_used + CNT_W'(1)};
                        end else begin
                            n_out = '{status: ST_NO_SLOT, slot_index: '0,
                                      found_handle: '0, occupancy: r_used};
                        end
                    end else begin
                        n_out = '{status: ST_NOT_FOUND, slot_index: '0, found_handle: '0,
                                  occupancy: r_used};
                    end
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_size      <= CNT_W'(TABLE_DEPTH);
            r_wr        <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_size      <= n_size;
            r_wr        <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_acc     <= n_acc;
        r_t       <= n_t;
        r_slot    <= n_slot;
        r_step    <= n_step;
        r_two     <= n_two;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_out     <= n_out;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH)) else $error("occupancy overflow");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("response dropped or changed while stalled");
endmodule

/* rtl/core/open_address_hash_table_top.sv */
// Top level: open-address hash table with APB size register
// Usage: send requests (kind, key, entry_handle) on the request channel;
// each yields one response (status, slot_index, found_handle, occupancy).
// One request is handled at a time; ready is low while a request is at work
// and while its response waits to be taken.
// Flow: after acceptance, S_HASH reduces the byte sum to the home slot by
// repeated subtraction of eight times the size or the size. Each probe
// then passes S_ADDR, S_WAIT and S_EVAL, as the cell store has one
// registered read port; a walk covers at most size probes, up to 256. A
// full table or an unused kind skips the probes and answers through S_DONE
// after the reduction; every request ends in S_DONE.
// Reset clears occupancy and sets the table size register to 256, then a
// clearing pass marks the 256 cells empty, one a cycle; ready stays low
// during the pass. A stalled response is held until taken.
// table_size is written through APB at address 0; the user writes it only
// while idle, which the block itself does not enforce; 0 acts as 1 and
// values above 256 act as 256.
module open_address_hash_table_top
    import oaht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaht_req_if.sink    req,
    oaht_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [8:0]       r_table_size;
    logic [IDX_W-1:0] w_rd_addr;
    t_cell_wr         w_wr;
    t_cell_rd         w_rd;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TABLE_SIZE) ? {23'd0, r_table_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 9'd256;
        end else if (psel && penable && pwrite && paddr == REG_TABLE_SIZE) begin
            r_table_size <= pwdata[8:0];
        end
    end

    oaht_seq u_seq (
        .i_clk, .i_rst_n, .i_table_size(r_table_size), .req, .rsp,
        .o_rd_addr(w_rd_addr), .o_wr(w_wr), .i_rd(w_rd)
    );

    oaht_cells u_cells (
        .i_clk, .i_rd_addr(w_rd_addr), .i_wr(w_wr), .o_rd(w_rd)
    );
endmodule

/* tb/sv/oaht_checker.sv */
// Checker: tracks the hash table contents, predicts each response and compares
`timescale 1ns / 100ps
module oaht_checker
    import oaht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  t_req        req_pl,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  t_rsp        rsp_pl,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_responses
);
    logic [1:0]          cell_mark   [TABLE_DEPTH];
    logic [KEY_W-1:0]    cell_key    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] cell_handle [TABLE_DEPTH];
    int                  used_cells;
    logic [8:0]          size_reg;
    t_rsp                pending_rsps[$];

    function automatic int reach();
        if (size_reg == 0) return 1;
        if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(size_reg);
    endfunction

    function automatic int home_of(logic [KEY_W-1:0] key, int s);
        int sum;
        sum = HOME_BASE;
        for (int b = 0; b < KEY_BYTES; b++) sum += key[8*b +: 8];
        return sum % s;
    endfunction

    function automatic int locate(logic [KEY_W-1:0] key, int s);
        int h;
        int c;
        h = home_of(key, s);
        for (int t = 0; t < s; t++) begin
            c = (h + t * t) % s;
            if (cell_mark[c] == MARK_EMPTY) return -1;
            if (cell_mark[c] == MARK_USED && cell_key[c] == key) return c;
        end
        return -1;
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp o;
        int   s;
        int   hit;
        int   h;
        int   c;
        o = '0;
        o.status = ST_NOT_FOUND;
        s = reach();
        case (r.kind)
            KIND_INSERT: begin
                if (used_cells >= s) begin
                    o.status = ST_FULL;
                end else if (locate(r.key, s) >= 0) begin
                    o.status = ST_DUP;
                end else begin
                    o.status = ST_NO_SLOT;
                    h = home_of(r.key, s);
                    for (int t = 0; t < s; t++) begin
                        c = (h + t * t) % s;
                        if (cell_mark[c] != MARK_USED) begin
                            cell_mark[c]   = MARK_USED;
                            cell_key[c]    = r.key;
                            cell_handle[c] = r.entry_handle;
                            used_cells++;
                            o.status     = ST_OK;
                            o.slot_index = c[7:0];
                            break;
                        end
                    end
                end
            end
            KIND_REMOVE: begin
                hit = locate(r.key, s);
                if (hit >= 0) begin
                    cell_mark[hit] = MARK_DELETED;
                    used_cells--;
                    o.status     = ST_OK;
                    o.slot_index = hit[7:0];
                end
            end
            KIND_LOOKUP: begin
                hit = locate(r.key, s);
                if (hit >= 0) begin
                    o.status       = ST_OK;
                    o.slot_index   = hit[7:0];
                    o.found_handle = cell_handle[hit];
                end
            end
            default: ;
        endcase
        o.occupancy = used_cells[8:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                cell_mark[i]   = MARK_EMPTY;
                cell_key[i]    = '0;
                cell_handle[i] = '0;
            end
            used_cells = 0;
            size_reg   = 9'd256;
            pending_rsps.delete();
            o_errors    <= 0;
            o_responses <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_TABLE_SIZE)
                size_reg = pwdata[8:0];
            if (req_valid && req_ready)
                pending_rsps.push_back(apply_request(req_pl));
            if (rsp_valid && rsp_ready) begin
                o_responses <= o_responses + 1;
                if (pending_rsps.size() == 0) begin
                    $display("%0t: response with none expected, got %p", $time, rsp_pl);
                    o_errors <= o_errors + 1;
                end else begin
                    e = pending_rsps.pop_front();
                    if (e != rsp_pl) begin
                        $display("%0t: status exp %0d got %0d, slot exp %0d got %0d",
                                 $time, e.status, rsp_pl.status, e.slot_index,
                                 rsp_pl.slot_index);
                        $display("%0t: handle exp %h got %h, occupancy exp %0d got %0d",
                                 $time, e.found_handle, rsp_pl.found_handle,
                                 e.occupancy, rsp_pl.occupancy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/tb_open_address_hash_table_top.sv */
// Testbench top: drives requests and size writes, gives the verdict
`timescale 1ns / 100ps
module tb_open_address_hash_table_top;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          responses;
    int          sent;
    int          cycles;
    int          hold_left;
    bit          hold_go;
    bit          calm;
    logic [63:0] key_pool[24];

    oaht_req_if req();
    oaht_rsp_if rsp();

    open_address_hash_table_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    oaht_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_pl(req.payload),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_pl(rsp.payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_responses(responses)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                rsp.ready <= 1'b0;
                hold_left--;
            end else if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 400;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= calm || $urandom_range(99) >= 28;
            end
        end
    end

    task automatic send_request(input logic [1:0] k, input logic [63:0] key,
                                input logic [15:0] h);
        t_req r;
        r = '{kind: k, key: key, entry_handle: h};
        if (!calm && $urandom_range(99) < 28) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req.valid   <= 1'b1;
        req.payload <= r;
        do @(posedge i_clk); while (!req.ready);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (responses != sent);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TABLE_SIZE;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        logic [1:0]  k;
        logic [63:0] key;
        int          p;
        for (int i = 0; i < 24; i++) begin
            case ($urandom_range(2))
                0: key_pool[i] = {$urandom, $urandom};
                1: key_pool[i] = 64'($urandom_range(255));
                default: key_pool[i] = {$urandom, $urandom} & 64'h00FF_00FF_FF00_FF00;
            endcase
        end
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 45) k = KIND_INSERT;
            else if (p < 70) k = KIND_REMOVE;
            else if (p < 97) k = KIND_LOOKUP;
            else k = 2'd3;
            key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(23)];
            send_request(k, key, 16'($urandom));
        end
    endtask

    initial begin
        int phase_sizes[10];
        phase_sizes = '{256, 0, 300, 4, 7, 16, 64, 1, 3, 32};
        i_rst_n     = 1'b0;
        req.valid   = 1'b0;
        req.payload = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        hold_go     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(KIND_INSERT, 64'h0, 16'h0000);
        send_request(KIND_INSERT, '1, 16'hFFFF);
        send_request(KIND_LOOKUP, '1, 16'h0);
        send_request(KIND_LOOKUP, 64'h0, 16'h0);
        send_request(KIND_INSERT, '1, 16'h1234);
        send_request(KIND_LOOKUP, 64'h0100_0000_0000_0000, 16'h0);
        send_request(KIND_REMOVE, '1, 16'h0);
        send_request(KIND_REMOVE, '1, 16'h0);
        send_request(KIND_LOOKUP, '1, 16'h0);
        send_request(2'd3, 64'h0, 16'hAAAA);
        write_size(32'd1);
        send_request(KIND_INSERT, 64'h5A, 16'h5555);
        send_request(KIND_INSERT, 64'hA5, 16'h0001);
        send_request(KIND_REMOVE, 64'h5A, 16'h0);
        send_request(KIND_INSERT, 64'hA5, 16'h8000);
        write_size(32'd4);
        send_request(KIND_INSERT, 64'h01, 16'h0011);
        send_request(KIND_INSERT, 64'h05, 16'h0022);
        send_request(KIND_INSERT, 64'h09, 16'h0033);
        send_request(KIND_LOOKUP, 64'h05, 16'h0);
        write_size(32'd2);
        send_request(KIND_INSERT, 64'h0D, 16'h0044);

        for (int ph = 0; ph < 10; ph++) begin
            write_size(phase_sizes[ph]);
            calm = (ph == 2);
            if (ph == 0) hold_go = 1'b1;
            random_phase(173);
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests, %0d responses checked, sizes 0..300 incl. 1 and 256",
                 sent, responses);
        if (errors == 0 && responses == sent) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/oaht_pkg.sv
rtl/core/oaht_if.sv
rtl/core/oaht_cells.sv
rtl/core/oaht_seq.sv
rtl/core/open_address_hash_table_top.sv
tb/sv/oaht_checker.sv
tb/sv/tb_open_address_hash_table_top.sv
